[hw/rtl/cfcs_pkg.sv]
// Shared types and constants of the cultural feature copy step block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package cfcs_pkg;

  // Fixed field widths of the ports.
  localparam int NF_W       = 5;
  localparam int AGENT_W    = 8;
  localparam int SLOT_W_IO  = 4;
  localparam int TRAIT_W_IO = 8;
  localparam int DRAW_W     = 4;

  // Feature count after reset.
  localparam logic [NF_W-1:0] NF_RESET = 5'd16;

  // Command codes of an input item.
  typedef logic [1:0] cmd_code_t;
  localparam cmd_code_t CMD_WRITE    = 2'd0;
  localparam cmd_code_t CMD_READ     = 2'd1;
  localparam cmd_code_t CMD_INTERACT = 2'd2;

  // Which fields a result carries.
  typedef logic [1:0] res_kind_t;
  localparam res_kind_t RES_STAT = 2'd0;
  localparam res_kind_t RES_READ = 2'd1;
  localparam res_kind_t RES_LINK = 2'd2;
  localparam res_kind_t RES_COPY = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      ld_item;
    logic      clr_pass;
    logic      issue_pair;
    logic      ld_scan;
    logic      scan_step;
    logic      issue_tgt;
    logic      wr_item;
    logic      wr_copy;
    logic      emit;
    res_kind_t res_kind;
    logic      err;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_code_t code;
    logic      rw_bad;
    logic      pair_bad;
    logic      nf_zero;
    logic      last_issue;
    logic      draw_bad;
    logic      take;
    logic      diff_here;
  } dp_sts_t;

endpackage

`default_nettype wire

[hw/rtl/cfcs_ram.sv]
// Generic simple RAM: one write port and two read ports with registered data.
// Depends on nothing.
`default_nettype none

module cfcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr_a,
  output logic      [WIDTH-1:0]  rdata_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and both registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[hw/rtl/cfcs_ctrl.sv]
// Controller state machine of the cultural feature copy step block.
// Depends on cfcs_pkg; drives the datapath through command and status structs.
`default_nettype none

module cfcs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire cfcs_pkg::dp_sts_t   sts,
  output cfcs_pkg::ctrl_cmd_t      cmd
);

  import cfcs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_RWAIT  = 3'd2;
  localparam logic [2:0] S_HPASS  = 3'd3;
  localparam logic [2:0] S_HDRAIN = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_SCAN   = 3'd6;
  localparam logic [2:0] S_TWAIT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.ld_item = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (sts.code)
          CMD_WRITE: begin
            cmd.wr_item  = !sts.rw_bad;
            cmd.emit     = 1'b1;
            cmd.res_kind = RES_STAT;
            cmd.err      = sts.rw_bad;
            state_next   = S_IDLE;
          end
          CMD_READ: begin
            if (sts.rw_bad) begin
              cmd.emit     = 1'b1;
              cmd.res_kind = RES_STAT;
              cmd.err      = 1'b1;
              state_next   = S_IDLE;
            end else begin
              state_next = S_RWAIT;
            end
          end
          CMD_INTERACT: begin
            if (sts.pair_bad) begin
              cmd.emit     = 1'b1;
              cmd.res_kind = RES_STAT;
              cmd.err      = 1'b1;
              state_next   = S_IDLE;
            end else begin
              cmd.clr_pass = 1'b1;
              state_next   = sts.nf_zero ? S_DECIDE : S_HPASS;
            end
          end
          default: begin
            cmd.emit     = 1'b1;
            cmd.res_kind = RES_STAT;
            cmd.err      = 1'b1;
            state_next   = S_IDLE;
          end
        endcase
      end
      S_RWAIT: begin
        cmd.emit     = 1'b1;
        cmd.res_kind = RES_READ;
        state_next   = S_IDLE;
      end
      S_HPASS: begin
        // One feature pair read per cycle.
        cmd.issue_pair = 1'b1;
        if (sts.last_issue) begin
          state_next = S_HDRAIN;
        end
      end
      S_HDRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts.draw_bad && sts.take) begin
          cmd.ld_scan = 1'b1;
          state_next  = S_SCAN;
        end else begin
          cmd.emit     = 1'b1;
          cmd.res_kind = RES_LINK;
          state_next   = S_IDLE;
        end
      end
      S_SCAN: begin
        // Walk the difference mask cyclically until a differing slot turns up.
        if (sts.diff_here) begin
          cmd.issue_tgt = 1'b1;
          state_next    = S_TWAIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_TWAIT: begin
        cmd.wr_copy  = 1'b1;
        cmd.emit     = 1'b1;
        cmd.res_kind = RES_COPY;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A result is never emitted from idle.
  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !cmd.emit)
    else $error("result emitted while idle");

  // The copy write always follows the read of the target value.
  a_copy_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_copy |-> $past(cmd.issue_tgt))
    else $error("copy write without target read");

  // The homophily pass stays in its two states after each pair read.
  a_pass_order: assert property (@(posedge clk) disable iff (rst)
    cmd.issue_pair |=> state == S_HPASS || state == S_HDRAIN)
    else $error("homophily pass left early");

endmodule

`default_nettype wire

[hw/rtl/cfcs_dpath.sv]
// Datapath of the cultural feature copy step block: item and config registers,
// feature memory, homophily counter, difference mask, scan pointer and results.
// Depends on cfcs_pkg and cfcs_ram.
`default_nettype none

module cfcs_dpath #(
  parameter int AGENTS       = 256,
  parameter int MAX_FEATURES = 16,
  parameter int TRAIT_BITS   = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire cfcs_pkg::ctrl_cmd_t                 cmd,
  output cfcs_pkg::dp_sts_t                        sts,
  input  wire cfcs_pkg::cmd_code_t                 cmd_in,
  input  wire logic [cfcs_pkg::AGENT_W-1:0]        source_agent,
  input  wire logic [cfcs_pkg::AGENT_W-1:0]        target_agent,
  input  wire logic [cfcs_pkg::SLOT_W_IO-1:0]      feature_slot,
  input  wire logic [cfcs_pkg::TRAIT_W_IO-1:0]     trait_value,
  input  wire logic [cfcs_pkg::DRAW_W-1:0]         draw_interact,
  input  wire logic [cfcs_pkg::DRAW_W-1:0]         draw_feature,
  input  wire logic                                cfg_wr_en,
  input  wire logic [cfcs_pkg::NF_W-1:0]           cfg_wr_data,
  output logic                                     done,
  output logic      [cfcs_pkg::TRAIT_W_IO-1:0]     read_value,
  output logic      [cfcs_pkg::NF_W-1:0]           shared_count,
  output logic                                     link_active,
  output logic                                     copied,
  output logic      [cfcs_pkg::SLOT_W_IO-1:0]      changed_slot,
  output logic                                     status
);

  import cfcs_pkg::*;

  localparam int DEPTH  = AGENTS * MAX_FEATURES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_FEATURES);

  // Captured item.
  cmd_code_t               item_cmd;
  logic [AGENT_W-1:0]      item_src;
  logic [AGENT_W-1:0]      item_tgt;
  logic [SLOT_W_IO-1:0]    item_slot;
  logic [TRAIT_W_IO-1:0]   item_value;
  logic [DRAW_W-1:0]       item_draw_int;
  logic [DRAW_W-1:0]       item_draw_feat;

  logic [NF_W-1:0]         num_features;
  logic [NF_W-1:0]         nf;

  logic [NF_W-1:0]         pass_idx;
  logic                    cmp_valid;
  logic [SLOT_W-1:0]       cmp_slot;
  logic [NF_W-1:0]         count;
  logic                    diff_mask [MAX_FEATURES];
  logic [NF_W-1:0]         scan_pos;
  logic [NF_W-1:0]         scan_pos_next;

  logic [NF_W-1:0]         rd_slot;
  logic [ADDR_W-1:0]       src_row;
  logic [ADDR_W-1:0]       tgt_row;
  logic [ADDR_W-1:0]       raddr_a;
  logic [ADDR_W-1:0]       raddr_b;
  logic                    ram_we;
  logic [ADDR_W-1:0]       waddr;
  logic [TRAIT_BITS-1:0]   wdata;
  logic [TRAIT_BITS-1:0]   rdata_a;
  logic [TRAIT_BITS-1:0]   rdata_b;

  logic                    src_bad;
  logic                    tgt_bad;
  logic                    active;

  logic [TRAIT_W_IO-1:0]   rv_next;
  logic [NF_W-1:0]         sc_next;
  logic                    la_next;
  logic                    cp_next;
  logic [SLOT_W_IO-1:0]    cs_next;
  logic                    st_next;

  // Effective feature count, limited to the table row length.
  assign nf = (32'(num_features) > MAX_FEATURES) ? NF_W'(MAX_FEATURES) : num_features;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_features <= NF_RESET;
    end else if (cfg_wr_en) begin
      num_features <= cfg_wr_data;
    end
  end

  // Item capture at each input transfer.
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      item_cmd       <= cmd_in;
      item_src       <= source_agent;
      item_tgt       <= target_agent;
      item_slot      <= feature_slot;
      item_value     <= trait_value;
      item_draw_int  <= draw_interact;
      item_draw_feat <= draw_feature;
    end
  end

  // Range checks and decisions for the controller.
  assign src_bad = 32'(item_src) >= AGENTS;
  assign tgt_bad = 32'(item_tgt) >= AGENTS;
  assign active  = (count != '0) && (count < nf);

  always_comb begin
    sts            = '0;
    sts.code       = item_cmd;
    sts.rw_bad     = src_bad || (NF_W'(item_slot) >= nf);
    sts.pair_bad   = src_bad || tgt_bad;
    sts.nf_zero    = (nf == '0);
    sts.last_issue = (pass_idx == nf - NF_W'(1));
    sts.draw_bad   = (NF_W'(item_draw_int) >= nf) || (NF_W'(item_draw_feat) >= nf);
    sts.take       = active && (NF_W'(item_draw_int) < count);
    sts.diff_here  = diff_mask[SLOT_W'(scan_pos)];
  end

  // Memory addressing: one row of MAX_FEATURES entries per agent.
  always_comb begin
    if (cmd.issue_pair) begin
      rd_slot = pass_idx;
    end else if (cmd.issue_tgt) begin
      rd_slot = scan_pos;
    end else begin
      rd_slot = NF_W'(item_slot);
    end
  end

  assign src_row = ADDR_W'(ADDR_W'(item_src) * ROW_STRIDE);
  assign tgt_row = ADDR_W'(ADDR_W'(item_tgt) * ROW_STRIDE);
  assign raddr_a = src_row + ADDR_W'(rd_slot);
  assign raddr_b = tgt_row + ADDR_W'(rd_slot);

  assign ram_we = cmd.wr_item || cmd.wr_copy;
  assign waddr  = src_row + (cmd.wr_copy ? ADDR_W'(scan_pos) : ADDR_W'(item_slot));
  assign wdata  = cmd.wr_copy ? rdata_b : TRAIT_BITS'(item_value);

  cfcs_ram #(
    .WIDTH (TRAIT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Pair read index of the homophily pass.
  always_ff @(posedge clk) begin
    if (cmd.clr_pass) begin
      pass_idx <= '0;
    end else if (cmd.issue_pair) begin
      pass_idx <= pass_idx + NF_W'(1);
    end
  end

  // The compare runs in the cycle after each pair read.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.issue_pair;
    end
  end

  always_ff @(posedge clk) begin
    cmp_slot <= SLOT_W'(pass_idx);
  end

  // Homophily count and the mask of differing slots.
  always_ff @(posedge clk) begin
    if (cmd.clr_pass) begin
      count <= '0;
      for (int k = 0; k < MAX_FEATURES; k++) begin
        diff_mask[k] <= 1'b0;
      end
    end else if (cmp_valid) begin
      if (rdata_a == rdata_b) begin
        count <= count + NF_W'(1);
      end else begin
        diff_mask[cmp_slot] <= 1'b1;
      end
    end
  end

  // Cyclic scan pointer, wrapping at the feature count.
  assign scan_pos_next = (scan_pos + NF_W'(1) == nf) ? '0 : scan_pos + NF_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.ld_scan) begin
      scan_pos <= NF_W'(item_draw_feat);
    end else if (cmd.scan_step) begin
      scan_pos <= scan_pos_next;
    end
  end

  // Result field selection.
  always_comb begin
    rv_next = '0;
    sc_next = '0;
    la_next = 1'b0;
    cp_next = 1'b0;
    cs_next = '0;
    st_next = 1'b0;
    unique case (cmd.res_kind)
      RES_STAT: begin
        st_next = cmd.err;
      end
      RES_READ: begin
        rv_next = TRAIT_W_IO'(rdata_a);
      end
      RES_LINK: begin
        sc_next = count;
        la_next = active;
        st_next = sts.draw_bad;
      end
      RES_COPY: begin
        rv_next = TRAIT_W_IO'(rdata_b);
        sc_next = count;
        la_next = 1'b1;
        cp_next = 1'b1;
        cs_next = SLOT_W_IO'(scan_pos);
      end
      default: begin
        st_next = 1'b1;
      end
    endcase
  end

  // Result registers and the one-cycle strobe.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      read_value   <= rv_next;
      shared_count <= sc_next;
      link_active  <= la_next;
      copied       <= cp_next;
      changed_slot <= cs_next;
      status       <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  // Memory writes never overlap a pending compare of the homophily pass.
  a_wr_no_cmp: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !cmp_valid)
    else $error("memory write during homophily compare");

  // A copy only happens over an active link with no error.
  a_copy_link: assert property (@(posedge clk) disable iff (rst)
    done && copied |-> link_active && !status)
    else $error("copy reported without an active link");

  // The scan pointer only starts from an in-range draw.
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_scan |-> !sts.draw_bad && active)
    else $error("scan started without a valid draw");

endmodule

`default_nettype wire

[hw/rtl/cultural_feature_copy_step.sv]
// Top level of the cultural feature copy step block: controller and datapath.
// Depends on cfcs_pkg, cfcs_ctrl, cfcs_dpath and cfcs_ram.
//
// An item is taken when start is high and busy is low; each item gives exactly
// one result, shown for one cycle with done high, and the receiver cannot hold
// it off. Writes, unknown commands and out-of-range items show their result
// from the check state, reads from the read-wait state after it. An interaction
// reads one pair of feature entries (source and target) per cycle through the
// two read ports of the feature memory, skipping the pass when the feature count
// is zero, then drains the last compare and decides on the link; a copy then
// scans the difference mask cyclically from the drawn slot, reads the target
// value and writes it back to the source. Busy falls in the cycle the result is
// shown, so the next item can be taken while done is high. The feature memory
// is not cleared: an entry holds a defined value only after it was written.
`default_nettype none

module cultural_feature_copy_step #(
  parameter int AGENTS       = 256,
  parameter int MAX_FEATURES = 16,
  parameter int TRAIT_BITS   = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          cmd,
  input  wire logic [cfcs_pkg::AGENT_W-1:0]        source_agent,
  input  wire logic [cfcs_pkg::AGENT_W-1:0]        target_agent,
  input  wire logic [cfcs_pkg::SLOT_W_IO-1:0]      feature_slot,
  input  wire logic [cfcs_pkg::TRAIT_W_IO-1:0]     trait_value,
  input  wire logic [cfcs_pkg::DRAW_W-1:0]         draw_interact,
  input  wire logic [cfcs_pkg::DRAW_W-1:0]         draw_feature,
  input  wire logic                                cfg_wr_en,
  input  wire logic [cfcs_pkg::NF_W-1:0]           cfg_wr_data,
  output logic                                     done,
  output logic      [cfcs_pkg::TRAIT_W_IO-1:0]     read_value,
  output logic      [cfcs_pkg::NF_W-1:0]           shared_count,
  output logic                                     link_active,
  output logic                                     copied,
  output logic      [cfcs_pkg::SLOT_W_IO-1:0]      changed_slot,
  output logic                                     status
);

  import cfcs_pkg::*;

  ctrl_cmd_t ctl_cmd;
  dp_sts_t   dp_sts;

  // Sequencer.
  cfcs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (dp_sts),
    .cmd   (ctl_cmd)
  );

  // Storage, counting, scan and result registers.
  cfcs_dpath #(
    .AGENTS       (AGENTS),
    .MAX_FEATURES (MAX_FEATURES),
    .TRAIT_BITS   (TRAIT_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctl_cmd),
    .sts           (dp_sts),
    .cmd_in        (cmd),
    .source_agent  (source_agent),
    .target_agent  (target_agent),
    .feature_slot  (feature_slot),
    .trait_value   (trait_value),
    .draw_interact (draw_interact),
    .draw_feature  (draw_feature),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .done          (done),
    .read_value    (read_value),
    .shared_count  (shared_count),
    .link_active   (link_active),
    .copied        (copied),
    .changed_slot  (changed_slot),
    .status        (status)
  );

endmodule

`default_nettype wire
